@@ rtl/ejf_pkg.sv @@
package ejf_pkg;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [17:0] PI_Q16     = 18'd205887;
  localparam logic [16:0] SQRTPI_Q16 = 17'd116160;
  localparam logic [16:0] SQRT2_Q16  = 17'd92682;
  localparam logic [47:0] CAP47_C    = 48'h8000_0000_0000;
  localparam logic [47:0] LIM48_C    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MAX31_C    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [21:0]        surface_temp;
    logic [31:0]        sat_pressure;
    logic signed [31:0] prev_flux;
    logic               relax_on;
    logic               last_cell;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mass_flux;
    logic signed [31:0] recoil_pressure;
    logic [31:0]        max_change;
    logic               sweep_end;
  } out_t;

  typedef enum logic [2:0] {
    CFG_VAPOUR_TEMP       = 3'd0,
    CFG_HOT_TEMP          = 3'd1,
    CFG_VAPOUR_GAMMA      = 3'd2,
    CFG_AMBIENT_GAMMA     = 3'd3,
    CFG_VAPOUR_GAS_CONST  = 3'd4,
    CFG_AMBIENT_GAS_CONST = 3'd5,
    CFG_AMBIENT_TEMP      = 3'd6,
    CFG_RELAX_FACTOR      = 3'd7
  } cfg_idx_e;

  // effective values: zero ambient gamma, gas constants and ambient temp forced to one LSB, weight clamped to one
  typedef struct packed {
    logic [21:0] vapour_temp;
    logic [21:0] hot_temp;
    logic [17:0] vapour_gamma;
    logic [17:0] ambient_gamma;
    logic [23:0] vapour_gas_const;
    logic [23:0] ambient_gas_const;
    logic [21:0] ambient_temp;
    logic [16:0] relax_factor;
  } cfg_t;

  typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_SQRT} alu_op_e;
  typedef enum logic [1:0] {SH_0, SH_8, SH_16, SH_32} alu_sh_e;
  typedef enum logic [1:0] {CAP_NONE, CAP_47, CAP_48, CAP_31} alu_cap_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    alu_sh_e     sh;
    alu_cap_e    cap;
    logic [63:0] opa;
    logic [47:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_F, ST_SG, ST_M, ST_C1N, ST_C1, ST_CC, ST_PC, ST_SQ, ST_SC,
    ST_RVT, ST_RT, ST_R1, ST_R, ST_A, ST_AS, ST_CD, ST_BC, ST_BB, ST_SQ2,
    ST_GC, ST_GT, ST_MP, ST_W, ST_WP, ST_X, ST_E, ST_FL, ST_RA, ST_RB,
    ST_MM, ST_GP, ST_RC, ST_OUT
  } seq_state_e;

endpackage

@@ rtl/ejf_cfg.sv @@
module ejf_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_addr_i,
  input  logic [23:0]      cfg_wdata_i,
  output ejf_pkg::cfg_t    cfg_o
);

  logic [21:0] vt_q, ht_q, t0_q;
  logic [17:0] gv_q, g0_q;
  logic [23:0] rv_q, r0_q;
  logic [16:0] rf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 22'd0;
      ht_q <= 22'd256;
      gv_q <= 18'd109227;
      g0_q <= 18'd91750;
      rv_q <= 24'd256;
      r0_q <= 24'd256;
      t0_q <= 22'd76800;
      rf_q <= 17'd65536;
    end else if (cfg_we_i) begin
      case (ejf_pkg::cfg_idx_e'(cfg_addr_i))
        ejf_pkg::CFG_VAPOUR_TEMP:       vt_q <= cfg_wdata_i[21:0];
        ejf_pkg::CFG_HOT_TEMP:          ht_q <= cfg_wdata_i[21:0];
        ejf_pkg::CFG_VAPOUR_GAMMA:      gv_q <= cfg_wdata_i[17:0];
        ejf_pkg::CFG_AMBIENT_GAMMA:     g0_q <= cfg_wdata_i[17:0];
        ejf_pkg::CFG_VAPOUR_GAS_CONST:  rv_q <= cfg_wdata_i;
        ejf_pkg::CFG_AMBIENT_GAS_CONST: r0_q <= cfg_wdata_i;
        ejf_pkg::CFG_AMBIENT_TEMP:      t0_q <= cfg_wdata_i[21:0];
        ejf_pkg::CFG_RELAX_FACTOR:      rf_q <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.vapour_temp       = vt_q;
    cfg_o.hot_temp          = ht_q;
    cfg_o.vapour_gamma      = gv_q;
    cfg_o.ambient_gamma     = (g0_q == 18'd0) ? 18'd1 : g0_q;
    cfg_o.vapour_gas_const  = (rv_q == 24'd0) ? 24'd1 : rv_q;
    cfg_o.ambient_gas_const = (r0_q == 24'd0) ? 24'd1 : r0_q;
    cfg_o.ambient_temp      = (t0_q == 22'd0) ? 22'd1 : t0_q;
    cfg_o.relax_factor      = (rf_q > ejf_pkg::ONE_Q16) ? ejf_pkg::ONE_Q16 : rf_q;
  end

endmodule

@@ rtl/ejf_alu.sv @@
module ejf_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ejf_pkg::alu_req_t   req_i,
  output ejf_pkg::alu_rsp_t   rsp_o
);

  logic                 busy_q, done_q;
  logic [6:0]           cnt_q;
  ejf_pkg::alu_op_e     op_q;
  ejf_pkg::alu_sh_e     sh_q;
  ejf_pkg::alu_cap_e    cap_q;
  logic [63:0]          a_q, res_q;
  logic [47:0]          b_q;
  logic [95:0]          acc_q;
  logic [48:0]          rem_q;
  logic [31:0]          root_q;

  logic [6:0]  last_cnt;
  logic        fin;
  logic [63:0] start_a;
  logic [31:0] pa, pb;
  logic [63:0] pprod;
  logic [95:0] pp_sh;
  logic [49:0] dtrial;
  logic        dge;
  logic [48:0] srem, strial;
  logic        sge;
  logic [95:0] q, capv;
  logic [63:0] fin_res;

  always_comb begin
    case (op_q)
      ejf_pkg::ALU_MUL:  last_cnt = 7'd4;
      ejf_pkg::ALU_DIV:  last_cnt = 7'd64;
      ejf_pkg::ALU_SQRT: last_cnt = 7'd32;
      default:           last_cnt = 7'd4;
    endcase
  end

  assign fin = busy_q && (cnt_q == last_cnt);

  always_comb begin
    if (req_i.opa[63:48] != 16'd0) begin
      start_a = {ejf_pkg::LIM48_C, 16'd0};
    end else begin
      start_a = {req_i.opa[47:0], 16'd0};
    end
    if (req_i.op != ejf_pkg::ALU_SQRT) begin
      start_a = req_i.opa;
    end
  end

  // 48x48 product as four 32x32 partial products
  always_comb begin
    pa    = cnt_q[1] ? {16'd0, a_q[47:32]} : a_q[31:0];
    pb    = cnt_q[0] ? {16'd0, b_q[47:32]} : b_q[31:0];
    pprod = pa * pb;
    case (cnt_q[1:0])
      2'b00:   pp_sh = {32'd0, pprod};
      2'b11:   pp_sh = {pprod[31:0], 64'd0};
      default: pp_sh = {pprod, 32'd0};
    endcase
  end

  always_comb begin
    dtrial = {1'b0, rem_q[47:0], a_q[63]} - {2'd0, b_q};
    dge    = !dtrial[49];
    srem   = {rem_q[46:0], a_q[63:62]};
    strial = {15'd0, root_q, 2'b01};
    sge    = (srem >= strial);
  end

  always_comb begin
    case (op_q)
      ejf_pkg::ALU_MUL: begin
        case (sh_q)
          ejf_pkg::SH_0:  q = acc_q;
          ejf_pkg::SH_8:  q = acc_q >> 8;
          ejf_pkg::SH_16: q = acc_q >> 16;
          ejf_pkg::SH_32: q = acc_q >> 32;
          default:        q = acc_q;
        endcase
      end
      ejf_pkg::ALU_DIV:  q = {32'd0, a_q};
      ejf_pkg::ALU_SQRT: q = {64'd0, root_q};
      default:           q = acc_q;
    endcase
    case (cap_q)
      ejf_pkg::CAP_47: capv = {48'd0, ejf_pkg::CAP47_C};
      ejf_pkg::CAP_48: capv = {48'd0, ejf_pkg::LIM48_C};
      ejf_pkg::CAP_31: capv = {64'd0, ejf_pkg::MAX31_C};
      default:         capv = '0;
    endcase
    if (cap_q != ejf_pkg::CAP_NONE && q > capv) begin
      fin_res = capv[63:0];
    end else begin
      fin_res = q[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= fin;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      sh_q   <= req_i.sh;
      cap_q  <= req_i.cap;
      a_q    <= start_a;
      b_q    <= req_i.opb;
      acc_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && !fin) begin
      case (op_q)
        ejf_pkg::ALU_MUL: acc_q <= acc_q + pp_sh;
        ejf_pkg::ALU_DIV: begin
          rem_q <= dge ? dtrial[48:0] : {rem_q[47:0], a_q[63]};
          a_q   <= {a_q[62:0], dge};
        end
        ejf_pkg::ALU_SQRT: begin
          rem_q  <= sge ? (srem - strial) : srem;
          root_q <= {root_q[30:0], sge};
          a_q    <= {a_q[61:0], 2'b00};
        end
        default: ;
      endcase
    end
    if (fin) begin
      res_q <= fin_res;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

@@ rtl/evaporation_jump_flux_core.sv @@
// Evaporation jump flux core: one surface cell per item in, one result item
// out. All multiplies, divides and square roots run on one shared unit under
// a step sequencer: a multiply sums four 32x32 partial products, a divide
// makes one quotient bit per cycle and a square root one root bit per cycle.
// A cell runs up to six divides and five square roots on that unit; the
// input is not ready while a cell is in work. The result sits in an output
// register, so the next cell may be taken while it waits. The running
// maximum of flux change is reported with every result and cleared after
// the cell marked last.
module evaporation_jump_flux_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_addr_i,
  input  logic [23:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ejf_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ejf_pkg::out_t  out_data_o
);

  ejf_pkg::cfg_t        cfg;
  ejf_pkg::alu_req_t    alu_req;
  ejf_pkg::alu_rsp_t    alu_rsp;
  ejf_pkg::seq_state_e  st_q, st_d;
  logic                 issued_q, issued_d;
  logic                 out_valid_q;
  ejf_pkg::out_t        out_q;
  logic [31:0]          rmax_q;

  logic [21:0]        t_q;
  logic [31:0]        p0_q;
  logic signed [31:0] prev_q;
  logic               relax_q, last_q;
  logic [16:0]        f_q, m_q, c1_q;
  logic [18:0]        s_q;
  logic [45:0]        rvt_q;
  logic [47:0]        cd_q, bc_q, pp_q;
  logic [31:0]        e_q, recoil_q;
  logic signed [31:0] flux_q;
  logic [63:0]        tmp_q;

  logic        in_fire, busy_st, skip, step_done, out_load;
  logic        f_special;
  logic [16:0] f_fixed;
  logic [17:0] gm1;
  logic [16:0] b_coef;
  logic [31:0] prev_mag;
  logic [47:0] pp_sum, d_val;
  logic [19:0] g_val;
  logic signed [49:0] rsum;
  logic [32:0] diff, absd;
  logic [31:0] chg, newmax;

  ejf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ejf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  function automatic ejf_pkg::seq_state_e seq_next(ejf_pkg::seq_state_e s, logic rlx);
    ejf_pkg::seq_state_e n;
    case (s)
      ejf_pkg::ST_F:   n = ejf_pkg::ST_SG;
      ejf_pkg::ST_SG:  n = ejf_pkg::ST_M;
      ejf_pkg::ST_M:   n = ejf_pkg::ST_C1N;
      ejf_pkg::ST_C1N: n = ejf_pkg::ST_C1;
      ejf_pkg::ST_C1:  n = ejf_pkg::ST_CC;
      ejf_pkg::ST_CC:  n = ejf_pkg::ST_PC;
      ejf_pkg::ST_PC:  n = ejf_pkg::ST_SQ;
      ejf_pkg::ST_SQ:  n = ejf_pkg::ST_SC;
      ejf_pkg::ST_SC:  n = ejf_pkg::ST_RVT;
      ejf_pkg::ST_RVT: n = ejf_pkg::ST_RT;
      ejf_pkg::ST_RT:  n = ejf_pkg::ST_R1;
      ejf_pkg::ST_R1:  n = ejf_pkg::ST_R;
      ejf_pkg::ST_R:   n = ejf_pkg::ST_A;
      ejf_pkg::ST_A:   n = ejf_pkg::ST_AS;
      ejf_pkg::ST_AS:  n = ejf_pkg::ST_CD;
      ejf_pkg::ST_CD:  n = ejf_pkg::ST_BC;
      ejf_pkg::ST_BC:  n = ejf_pkg::ST_BB;
      ejf_pkg::ST_BB:  n = ejf_pkg::ST_SQ2;
      ejf_pkg::ST_SQ2: n = ejf_pkg::ST_GC;
      ejf_pkg::ST_GC:  n = ejf_pkg::ST_GT;
      ejf_pkg::ST_GT:  n = ejf_pkg::ST_MP;
      ejf_pkg::ST_MP:  n = ejf_pkg::ST_W;
      ejf_pkg::ST_W:   n = ejf_pkg::ST_WP;
      ejf_pkg::ST_WP:  n = ejf_pkg::ST_X;
      ejf_pkg::ST_X:   n = ejf_pkg::ST_E;
      ejf_pkg::ST_E:   n = ejf_pkg::ST_FL;
      ejf_pkg::ST_FL:  n = rlx ? ejf_pkg::ST_RA : ejf_pkg::ST_MM;
      ejf_pkg::ST_RA:  n = ejf_pkg::ST_RB;
      ejf_pkg::ST_RB:  n = ejf_pkg::ST_MM;
      ejf_pkg::ST_MM:  n = ejf_pkg::ST_GP;
      ejf_pkg::ST_GP:  n = ejf_pkg::ST_RC;
      ejf_pkg::ST_RC:  n = ejf_pkg::ST_OUT;
      default:         n = ejf_pkg::ST_IDLE;
    endcase
    return n;
  endfunction

  // cheap datapath terms
  always_comb begin
    f_special = 1'b1;
    f_fixed   = 17'd0;
    if (cfg.hot_temp <= cfg.vapour_temp) begin
      f_fixed = (t_q > cfg.vapour_temp) ? ejf_pkg::ONE_Q16 : 17'd0;
    end else if (t_q <= cfg.vapour_temp) begin
      f_fixed = 17'd0;
    end else if (t_q >= cfg.hot_temp) begin
      f_fixed = ejf_pkg::ONE_Q16;
    end else begin
      f_special = 1'b0;
    end
    gm1      = (cfg.vapour_gamma > 18'd65536) ? (cfg.vapour_gamma - 18'd65536) : 18'd0;
    b_coef   = 17'((19'(cfg.ambient_gamma) + 19'd65536) >> 2);
    prev_mag = prev_q[31] ? (~prev_q + 32'd1) : prev_q;
    pp_sum   = alu_rsp.res[47:0] + 48'd65536;
    if (pp_sum > ejf_pkg::CAP47_C) begin
      pp_sum = ejf_pkg::CAP47_C;
    end
    g_val    = 20'd65536 + {1'b0, tmp_q[17:0], 1'b0};
    d_val    = (tmp_q[47:0] > 48'd65536) ? (tmp_q[47:0] - 48'd65536) : 48'd0;
    if (prev_q[31]) begin
      rsum = $signed({1'b0, tmp_q[48:0]}) - $signed({1'b0, alu_rsp.res[48:0]});
    end else begin
      rsum = $signed({1'b0, tmp_q[48:0]}) + $signed({1'b0, alu_rsp.res[48:0]});
    end
    diff   = {flux_q[31], flux_q} - {prev_q[31], prev_q};
    absd   = diff[32] ? (~diff + 33'd1) : diff;
    chg    = absd[31:0];
    newmax = (chg > rmax_q) ? chg : rmax_q;
  end

  assign in_ready_o = (st_q == ejf_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign busy_st    = (st_q != ejf_pkg::ST_IDLE) && (st_q != ejf_pkg::ST_OUT);
  assign skip       = ((st_q == ejf_pkg::ST_F) && f_special) ||
                      ((st_q == ejf_pkg::ST_FL) && (e_q == 32'd0));
  assign step_done  = busy_st && (skip || alu_rsp.done);
  assign out_load   = (st_q == ejf_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    st_d     = st_q;
    issued_d = issued_q;
    case (st_q)
      ejf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          st_d = ejf_pkg::ST_F;
        end
      end
      ejf_pkg::ST_OUT: begin
        if (out_load) begin
          st_d = ejf_pkg::ST_IDLE;
        end
      end
      default: begin
        if (step_done) begin
          st_d     = seq_next(st_q, relax_q);
          issued_d = 1'b0;
        end else if (alu_req.start) begin
          issued_d = 1'b1;
        end
      end
    endcase
  end

  // unit request per step
  always_comb begin
    alu_req       = '0;
    alu_req.start = busy_st && !skip && !issued_q;
    alu_req.op    = ejf_pkg::ALU_MUL;
    alu_req.sh    = ejf_pkg::SH_0;
    alu_req.cap   = ejf_pkg::CAP_NONE;
    case (st_q)
      ejf_pkg::ST_F: begin
        alu_req.op  = ejf_pkg::ALU_DIV;
        alu_req.opa = {26'd0, t_q - cfg.vapour_temp, 16'd0};
        alu_req.opb = {26'd0, cfg.hot_temp - cfg.vapour_temp};
      end
      ejf_pkg::ST_SG: begin
        alu_req.op  = ejf_pkg::ALU_SQRT;
        alu_req.opa = {47'd0, cfg.vapour_gamma[17:1]};
      end
      ejf_pkg::ST_M: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.opa = {47'd0, f_q};
        alu_req.opb = {31'd0, tmp_q[16:0]};
      end
      ejf_pkg::ST_C1N: begin
        alu_req.opa = {47'd0, m_q};
        alu_req.opb = {30'd0, gm1};
      end
      ejf_pkg::ST_C1: begin
        alu_req.op  = ejf_pkg::ALU_DIV;
        alu_req.opa = tmp_q;
        alu_req.opb = {28'd0, 19'(cfg.vapour_gamma) + 19'd65536, 1'b0};
      end
      ejf_pkg::ST_CC: begin
        alu_req.opa = {47'd0, c1_q};
        alu_req.opb = {31'd0, c1_q};
      end
      ejf_pkg::ST_PC: begin
        alu_req.sh  = ejf_pkg::SH_32;
        alu_req.opa = {46'd0, ejf_pkg::PI_Q16};
        alu_req.opb = tmp_q[47:0];
      end
      ejf_pkg::ST_SQ: begin
        alu_req.op  = ejf_pkg::ALU_SQRT;
        alu_req.opa = tmp_q + 64'd65536;
      end
      ejf_pkg::ST_SC: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.opa = {47'd0, ejf_pkg::SQRTPI_Q16};
        alu_req.opb = {31'd0, c1_q};
      end
      ejf_pkg::ST_RVT: begin
        alu_req.opa = {40'd0, cfg.vapour_gas_const};
        alu_req.opb = {26'd0, t_q};
      end
      ejf_pkg::ST_RT: begin
        alu_req.opa = {40'd0, cfg.ambient_gas_const};
        alu_req.opb = {26'd0, cfg.ambient_temp};
      end
      ejf_pkg::ST_R1: begin
        alu_req.op  = ejf_pkg::ALU_DIV;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {1'b0, rvt_q, 17'd0};
        alu_req.opb = tmp_q[47:0];
      end
      ejf_pkg::ST_R: begin
        alu_req.op  = ejf_pkg::ALU_DIV;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {tmp_q[47:0], 16'd0};
        alu_req.opb = {30'd0, cfg.ambient_gamma};
      end
      ejf_pkg::ST_A: begin
        alu_req.op  = ejf_pkg::ALU_SQRT;
        alu_req.opa = tmp_q;
      end
      ejf_pkg::ST_AS: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {16'd0, tmp_q[47:0]};
        alu_req.opb = {29'd0, s_q};
      end
      ejf_pkg::ST_CD: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {16'd0, tmp_q[47:0]};
        alu_req.opb = {31'd0, m_q};
      end
      ejf_pkg::ST_BC: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {47'd0, b_coef};
        alu_req.opb = cd_q;
      end
      ejf_pkg::ST_BB: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {16'd0, bc_q};
        alu_req.opb = bc_q;
      end
      ejf_pkg::ST_SQ2: begin
        alu_req.op  = ejf_pkg::ALU_SQRT;
        alu_req.opa = tmp_q + 64'd65536;
      end
      ejf_pkg::ST_GC: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {46'd0, cfg.ambient_gamma};
        alu_req.opb = cd_q;
      end
      ejf_pkg::ST_GT: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {16'd0, tmp_q[47:0]};
        alu_req.opb = bc_q;
      end
      ejf_pkg::ST_MP: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {47'd0, m_q};
        alu_req.opb = pp_q;
      end
      ejf_pkg::ST_W: begin
        alu_req.op  = ejf_pkg::ALU_DIV;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {tmp_q[47:0], 16'd0};
        alu_req.opb = {29'd0, s_q};
      end
      ejf_pkg::ST_WP: begin
        alu_req.sh  = ejf_pkg::SH_8;
        alu_req.cap = ejf_pkg::CAP_48;
        alu_req.opa = {16'd0, tmp_q[47:0]};
        alu_req.opb = {16'd0, p0_q};
      end
      ejf_pkg::ST_X: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_48;
        alu_req.opa = {16'd0, tmp_q[47:0]};
        alu_req.opb = {31'd0, ejf_pkg::SQRT2_Q16};
      end
      ejf_pkg::ST_E: begin
        alu_req.op  = ejf_pkg::ALU_SQRT;
        alu_req.opa = {18'd0, rvt_q};
      end
      ejf_pkg::ST_FL: begin
        alu_req.op  = ejf_pkg::ALU_DIV;
        alu_req.cap = ejf_pkg::CAP_31;
        alu_req.opa = {tmp_q[47:0], 16'd0};
        alu_req.opb = {16'd0, e_q};
      end
      ejf_pkg::ST_RA: begin
        alu_req.opa = {47'd0, cfg.relax_factor};
        alu_req.opb = {16'd0, flux_q};
      end
      ejf_pkg::ST_RB: begin
        alu_req.opa = {47'd0, ejf_pkg::ONE_Q16 - cfg.relax_factor};
        alu_req.opb = {16'd0, prev_mag};
      end
      ejf_pkg::ST_MM: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.opa = {47'd0, m_q};
        alu_req.opb = {31'd0, m_q};
      end
      ejf_pkg::ST_GP: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_47;
        alu_req.opa = {44'd0, g_val};
        alu_req.opb = pp_q;
      end
      ejf_pkg::ST_RC: begin
        alu_req.sh  = ejf_pkg::SH_16;
        alu_req.cap = ejf_pkg::CAP_31;
        alu_req.opa = {16'd0, d_val};
        alu_req.opb = {16'd0, p0_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ejf_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rmax_q      <= 32'd0;
    end else begin
      st_q     <= st_d;
      issued_q <= issued_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        rmax_q      <= last_q ? 32'd0 : newmax;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      t_q     <= in_data_i.surface_temp;
      p0_q    <= in_data_i.sat_pressure;
      prev_q  <= in_data_i.prev_flux;
      relax_q <= in_data_i.relax_on;
      last_q  <= in_data_i.last_cell;
    end
    if (out_load) begin
      out_q.mass_flux       <= flux_q;
      out_q.recoil_pressure <= recoil_q;
      out_q.max_change      <= newmax;
      out_q.sweep_end       <= last_q;
    end
    if (step_done) begin
      case (st_q)
        ejf_pkg::ST_F:   f_q <= f_special ? f_fixed : alu_rsp.res[16:0];
        ejf_pkg::ST_M:   m_q <= alu_rsp.res[16:0];
        ejf_pkg::ST_C1:  c1_q <= alu_rsp.res[16:0];
        ejf_pkg::ST_SC: begin
          s_q <= (tmp_q[18:0] > alu_rsp.res[18:0]) ? (tmp_q[18:0] - alu_rsp.res[18:0])
                                                   : 19'd1;
        end
        ejf_pkg::ST_RVT: rvt_q <= alu_rsp.res[45:0];
        ejf_pkg::ST_CD:  cd_q <= alu_rsp.res[47:0];
        ejf_pkg::ST_BC:  bc_q <= alu_rsp.res[47:0];
        ejf_pkg::ST_SQ2: bc_q <= bc_q + {16'd0, alu_rsp.res[31:0]};
        ejf_pkg::ST_GT:  pp_q <= pp_sum;
        ejf_pkg::ST_E:   e_q <= alu_rsp.res[31:0];
        ejf_pkg::ST_FL:  flux_q <= (e_q == 32'd0) ? 32'sd0 : $signed(alu_rsp.res[31:0]);
        ejf_pkg::ST_RB:  flux_q <= rsum[47:16];
        ejf_pkg::ST_RC:  recoil_q <= alu_rsp.res[31:0];
        default:         tmp_q <= alu_rsp.res;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> issued_q)
    else $error("unit result with no request outstanding");

  a_no_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!alu_req.start && !issued_q))
    else $error("unit started while idle");

  a_relax_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ejf_pkg::ST_RA || st_q == ejf_pkg::ST_RB) |-> relax_q)
    else $error("relaxation steps without relax_on");

  a_max_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (rmax_q == 32'd0))
    else $error("running maximum not cleared after last cell");
`endif

endmodule
